// File: hdl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, widths and constants of the polar/rectangular CORDIC converter.
// ----------------------------------------------------------------------------
package prc_pkg;

    // command codes
    localparam logic CMD_P2R = 1'b0;   // polar to rectangular (rotation)
    localparam logic CMD_R2P = 1'b1;   // rectangular to polar (vectoring)

    localparam int TABLE_LEN  = 24;
    localparam int ITERATIONS = 16;
    localparam int ITER_N     = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    localparam int IDX_W      = $clog2(TABLE_LEN);

    // extra fraction bits below Q8.8 in the datapath
    localparam int GUARD = 12;
    localparam int DW    = 32;   // x / y datapath width
    localparam int ZW    = 32;   // angle accumulator, 2^32 units per turn
    localparam int MAG_W = DW - 1;
    localparam int PROD_W = MAG_W + 32;
    localparam int SCALE_SHIFT = 32 + GUARD;
    localparam int RND_W = 64;
    localparam int Q_W   = RND_W - SCALE_SHIFT;

    localparam logic [31:0]      GAIN_INV   = 32'h9B74EDA8;
    localparam logic [RND_W-1:0] ROUND_HALF = 64'd1 << (SCALE_SHIFT - 1);

    localparam logic [ZW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // working vector of one beat
    typedef struct packed {
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic        [ZW-1:0] z;
    } prc_vec_t;

    // mode and pass-through fields that ride along with the beat
    typedef struct packed {
        logic        vec;       // vectoring (rectangular to polar)
        logic        zero;      // zero input vector
        logic [15:0] pass_hi;   // length_in (rotation) or x_in (vectoring)
        logic [15:0] pass_lo;   // angle_in  (rotation) or y_in (vectoring)
    } prc_side_t;

endpackage

// File: hdl/prc_prep.sv
// ----------------------------------------------------------------------------
// prc_prep
// Input stage: quadrant fold for rotation, half-plane fold for vectoring,
// scaling to the datapath format.
// ----------------------------------------------------------------------------
module prc_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               beat,
    input  logic               command,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    input  logic        [15:0] length_in,
    input  logic signed [15:0] angle_in,
    output logic               valid_reg,
    output prc_pkg::prc_vec_t  vec_reg,
    output prc_pkg::prc_side_t side_reg
);
    import prc_pkg::*;

    logic signed [16:0] ang_ext;
    logic signed [16:0] ang_adj;
    logic               flip;
    logic signed [DW-1:0] len_s;
    logic signed [DW-1:0] xv_s;
    logic signed [DW-1:0] yv_s;
    prc_vec_t  vec_next;
    prc_side_t side_next;

    always_comb
    begin
        ang_ext = {angle_in[15], angle_in};
        flip    = 1'b0;
        ang_adj = ang_ext;
        if (ang_ext > 17'sd16384)
        begin
            ang_adj = ang_ext - 17'sd32768;
            flip    = 1'b1;
        end
        else if (ang_ext < -17'sd16384)
        begin
            ang_adj = ang_ext + 17'sd32768;
            flip    = 1'b1;
        end

        len_s = DW'({length_in, {GUARD{1'b0}}});
        xv_s  = {{(DW-16-GUARD){x_in[15]}}, x_in, {GUARD{1'b0}}};
        yv_s  = {{(DW-16-GUARD){y_in[15]}}, y_in, {GUARD{1'b0}}};

        if (command == CMD_R2P)
        begin
            // fold the left half plane onto the right, start at pi
            if (x_in[15])
            begin
                vec_next.x = -xv_s;
                vec_next.y = -yv_s;
                vec_next.z = {1'b1, {(ZW-1){1'b0}}};
            end
            else
            begin
                vec_next.x = xv_s;
                vec_next.y = yv_s;
                vec_next.z = '0;
            end
            side_next.vec     = 1'b1;
            side_next.zero    = (x_in == 16'sd0) && (y_in == 16'sd0);
            side_next.pass_hi = x_in;
            side_next.pass_lo = y_in;
        end
        else
        begin
            vec_next.x = flip ? -len_s : len_s;
            vec_next.y = '0;
            vec_next.z = {ang_adj[15:0], 16'h0000};
            side_next.vec     = 1'b0;
            side_next.zero    = 1'b0;
            side_next.pass_hi = length_in;
            side_next.pass_lo = angle_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= beat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg  <= vec_next;
            side_reg <= side_next;
        end
    end

endmodule

// File: hdl/prc_rot.sv
// ----------------------------------------------------------------------------
// prc_rot
// One CORDIC micro-rotation stage; the stage index is tied to a constant.
// ----------------------------------------------------------------------------
module prc_rot (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic [prc_pkg::IDX_W-1:0] stage,
    input  logic                     valid_in,
    input  prc_pkg::prc_vec_t        vec_in,
    input  prc_pkg::prc_side_t       side_in,
    output logic                     valid_reg,
    output prc_pkg::prc_vec_t        vec_reg,
    output prc_pkg::prc_side_t       side_reg
);
    import prc_pkg::*;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic                 pos;
    prc_vec_t             vec_next;

    always_comb
    begin
        dx = vec_in.y >>> stage;
        dy = vec_in.x >>> stage;
        // rotation drives z to zero, vectoring drives y to zero
        pos = side_in.vec ? vec_in.y[DW-1] : ~vec_in.z[ZW-1];
        if (pos)
        begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - ATAN_TAB[stage];
        end
        else
        begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + ATAN_TAB[stage];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg  <= vec_next;
            side_reg <= side_in;
        end
    end

endmodule

// File: hdl/prc_scale.sv
// ----------------------------------------------------------------------------
// prc_scale
// Gain compensation and output formatting: magnitude, multiply by 1/K,
// round half away from zero, saturate, select pass-through fields.
// ----------------------------------------------------------------------------
module prc_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                valid_in,
    input  prc_pkg::prc_vec_t   vec_in,
    input  prc_pkg::prc_side_t  side_in,
    output logic                valid_reg,
    output logic signed [16:0]  x_out,
    output logic signed [16:0]  y_out,
    output logic        [15:0]  length_out,
    output logic signed [15:0]  angle_out
);
    import prc_pkg::*;

    // stage A: sign and magnitude, rounded angle
    logic                 a_valid_reg;
    logic                 a_xneg_reg, a_yneg_reg;
    logic [MAG_W-1:0]     a_xmag_reg, a_ymag_reg;
    logic [15:0]          a_ang_reg;
    prc_side_t            a_side_reg;
    logic [DW-1:0]        xabs_next, yabs_next;
    logic [ZW-1:0]        zrnd_next;

    // stage B: products
    logic                 b_valid_reg;
    logic                 b_xneg_reg, b_yneg_reg;
    logic [PROD_W-1:0]    b_xprod_reg, b_yprod_reg;
    logic [15:0]          b_ang_reg;
    prc_side_t            b_side_reg;

    // stage C: output register
    logic [RND_W-1:0]     xrnd, yrnd;
    logic [Q_W-1:0]       xq, yq;
    logic [15:0]          xsat, ysat;
    logic signed [16:0]   xfin, yfin;
    logic signed [16:0]   x_next, y_next;
    logic [15:0]          length_next;
    logic [15:0]          angle_next;

    always_comb
    begin
        xabs_next = vec_in.x[DW-1] ? DW'(-vec_in.x) : DW'(vec_in.x);
        yabs_next = vec_in.y[DW-1] ? DW'(-vec_in.y) : DW'(vec_in.y);
        zrnd_next = vec_in.z + ZW'(32'h8000);
    end

    always_comb
    begin
        xrnd = RND_W'(b_xprod_reg) + ROUND_HALF;
        yrnd = RND_W'(b_yprod_reg) + ROUND_HALF;
        xq   = xrnd[RND_W-1:SCALE_SHIFT];
        yq   = yrnd[RND_W-1:SCALE_SHIFT];
        xsat = (|xq[Q_W-1:16]) ? 16'hFFFF : xq[15:0];
        ysat = (|yq[Q_W-1:16]) ? 16'hFFFF : yq[15:0];
        xfin = b_xneg_reg ? -$signed({1'b0, xsat}) : $signed({1'b0, xsat});
        yfin = b_yneg_reg ? -$signed({1'b0, ysat}) : $signed({1'b0, ysat});

        if (b_side_reg.vec)
        begin
            x_next      = {b_side_reg.pass_hi[15], b_side_reg.pass_hi};
            y_next      = {b_side_reg.pass_lo[15], b_side_reg.pass_lo};
            length_next = b_side_reg.zero ? 16'h0000 : xfin[15:0];
            angle_next  = b_side_reg.zero ? 16'h0000 : b_ang_reg;
        end
        else
        begin
            x_next      = xfin;
            y_next      = yfin;
            length_next = b_side_reg.pass_hi;
            angle_next  = b_side_reg.pass_lo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
            valid_reg   <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_xneg_reg  <= vec_in.x[DW-1];
            a_yneg_reg  <= vec_in.y[DW-1];
            a_xmag_reg  <= xabs_next[MAG_W-1:0];
            a_ymag_reg  <= yabs_next[MAG_W-1:0];
            a_ang_reg   <= zrnd_next[ZW-1:ZW-16];
            a_side_reg  <= side_in;

            b_xneg_reg  <= a_xneg_reg;
            b_yneg_reg  <= a_yneg_reg;
            b_xprod_reg <= PROD_W'(a_xmag_reg) * PROD_W'(GAIN_INV);
            b_yprod_reg <= PROD_W'(a_ymag_reg) * PROD_W'(GAIN_INV);
            b_ang_reg   <= a_ang_reg;
            b_side_reg  <= a_side_reg;

            x_out       <= x_next;
            y_out       <= y_next;
            length_out  <= length_next;
            angle_out   <= angle_next;
        end
    end

endmodule

// File: hdl/polar_rect_converter_core.sv
// ----------------------------------------------------------------------------
// polar_rect_converter_core
// Stages: one input stage, one register per CORDIC micro-rotation and three
// gain/format stages.
// Throughput: one beat per cycle; the whole pipeline holds while the result
// beat waits, so cmd_ready follows res_ready or an empty output register.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module polar_rect_converter_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic               command,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    input  logic        [15:0] length_in,
    input  logic signed [15:0] angle_in,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [16:0] x_out,
    output logic signed [16:0] y_out,
    output logic        [15:0] length_out,
    output logic signed [15:0] angle_out
);
    import prc_pkg::*;

    logic      adv;
    logic      valid_pipe [0:ITER_N];
    prc_vec_t  vec_pipe   [0:ITER_N];
    prc_side_t side_pipe  [0:ITER_N];

    // advance everything unless a finished beat is stuck at the output
    assign adv       = res_ready | ~res_valid;
    assign cmd_ready = adv;

    prc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .beat      (cmd_valid),
        .command   (command),
        .x_in      (x_in),
        .y_in      (y_in),
        .length_in (length_in),
        .angle_in  (angle_in),
        .valid_reg (valid_pipe[0]),
        .vec_reg   (vec_pipe[0]),
        .side_reg  (side_pipe[0])
    );

    for (genvar i = 0; i < ITER_N; i++)
    begin : g_rot
        prc_rot u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .stage     (IDX_W'(i)),
            .valid_in  (valid_pipe[i]),
            .vec_in    (vec_pipe[i]),
            .side_in   (side_pipe[i]),
            .valid_reg (valid_pipe[i+1]),
            .vec_reg   (vec_pipe[i+1]),
            .side_reg  (side_pipe[i+1])
        );
    end

    prc_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .valid_in   (valid_pipe[ITER_N]),
        .vec_in     (vec_pipe[ITER_N]),
        .side_in    (side_pipe[ITER_N]),
        .valid_reg  (res_valid),
        .x_out      (x_out),
        .y_out      (y_out),
        .length_out (length_out),
        .angle_out  (angle_out)
    );

endmodule
